@@ design/ats_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

    // Table size and fixed-point format.
    localparam int TRACKS    = 16;
    localparam int FRAC_BITS = 8;

    // Derived widths.
    localparam int IDX_W   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int CNT_W   = $clog2(TRACKS + 1);
    localparam int INT_W   = 12;
    localparam int POS_W   = INT_W + FRAC_BITS;
    localparam int SECS_W  = 16;
    localparam int FPS_W   = 8;
    localparam int PROD_W  = SECS_W + FPS_W;
    localparam int SHIFT   = SECS_W - FRAC_BITS;
    localparam int ADV_W   = PROD_W - SHIFT;
    localparam int ID_W    = 8;
    localparam int FC_W    = 13;
    localparam int FRAME_W = 20;
    localparam int CMD_W   = 3;
    localparam int CMP_W   = (POS_W > FRAME_W) ? POS_W : FRAME_W;

    localparam logic [FC_W-1:0]  MAX_FRAMES = FC_W'(4096);
    localparam logic [POS_W-1:0] POS_MAX    = '1;
    localparam logic [FPS_W-1:0] FPS_RESET  = FPS_W'(30);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HOLD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIRE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STEP  = 3'd4;

    // One table entry. The frame count is kept as its last frame index,
    // since a stored track always has between one and 4096 frames.
    typedef struct packed {
        logic [ID_W-1:0]  object_id;
        logic [INT_W-1:0] last_frame;
        logic [POS_W-1:0] position;
        logic             reverse;
        logic             once;
        logic             finished;
    } entry_t;

endpackage

`default_nettype wire

@@ design/animation_track_frame_stepper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Animation track frame stepper. The block keeps a table of up to TRACKS
// animation tracks in a single-port-read, single-port-write memory and takes
// one command word at a time on the input channel. Clear and load finish in
// the cycle the word is accepted. Hold and fire search the table for the
// first track with the matching object id, reading one entry per cycle. A
// step reads the stored tracks in table order at one entry per cycle while
// the output is not stalled, sends each track's position before the advance
// as one result word, and writes the advanced entry back in the same cycle;
// its pace is limited by the memory read port and by the output channel
// when it stalls. The advance is seconds times frames_per_second, truncated
// to the frame fraction, computed once when the step word is accepted. The
// input channel is ready only between commands, while the last result of a
// step may still wait in the output register.
// The frames_per_second register resets to 30 and may be written only while
// the block is idle. A step on an empty table gives no result words.
module animation_track_frame_stepper
    import ats_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_wr_en,
    input  wire logic [FPS_W-1:0]     cfg_wr_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     command,
    input  wire logic [ID_W-1:0]      object_id,
    input  wire logic [FC_W-1:0]      frame_count,
    input  wire logic [FRAME_W-1:0]   start_frame,
    input  wire logic                 reverse_flag,
    input  wire logic                 once_flag,
    input  wire logic                 open_flag,
    input  wire logic                 at_once_flag,
    input  wire logic [SECS_W-1:0]    seconds,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ID_W-1:0]           track_object,
    output logic [FRAME_W-1:0]        frame_value,
    output logic                      is_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;

    // Control state.
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             p1_valid_reg, p1_valid_next;
    logic [IDX_W-1:0] p1_idx_reg, p1_idx_next;
    logic [FPS_W-1:0] fps_reg;
    logic             out_valid_reg;

    // Command operands held for the duration of a step or search.
    logic [ADV_W-1:0] adv_reg;
    logic [ID_W-1:0]  find_id_reg;
    logic             find_fire_reg;
    logic             open_reg;
    logic             at_once_reg;

    // Output payload.
    logic [ID_W-1:0]    track_object_reg;
    logic [FRAME_W-1:0] frame_value_reg;
    logic               is_last_reg;

    // Memory ports.
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;
    entry_t           stepped;

    logic             accept;
    logic [IDX_W-1:0] last_idx;
    logic             p1_is_last;
    logic             step_consume;
    logic             find_hit;
    logic             find_end;
    logic             more_to_read;

    // Load datapath.
    logic [FC_W-1:0]  fc_sat;
    logic [INT_W-1:0] load_last_frame;
    logic [POS_W-1:0] load_last_pos;
    logic             load_ok;
    entry_t           load_entry;

    // Hold and fire datapath.
    entry_t           found_entry;

    logic [PROD_W-1:0] product;

    ats_track_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ats_track_update u_update (
        .cur (mem_rd_data),
        .adv (adv_reg),
        .nxt (stepped)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign track_object = track_object_reg;
    assign frame_value  = frame_value_reg;
    assign is_last      = is_last_reg;

    assign last_idx     = IDX_W'(total_reg - CNT_W'(1));
    assign p1_is_last   = (p1_idx_reg == last_idx);
    assign more_to_read = (rd_idx_reg < total_reg);
    assign step_consume = (state_reg == ST_STEP) && p1_valid_reg
                          && (!out_valid_reg || out_ready);
    assign find_hit     = (state_reg == ST_FIND) && p1_valid_reg
                          && (mem_rd_data.object_id == find_id_reg);
    assign find_end     = (state_reg == ST_FIND) && p1_valid_reg
                          && (find_hit || p1_is_last);

    // Load entry: the frame count saturates at 4096 and the start position is
    // clamped to the last frame; reverse tracks start at the last frame.
    always_comb
    begin
        fc_sat          = (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
        load_last_frame = INT_W'(fc_sat - FC_W'(1));
        load_last_pos   = {load_last_frame, {FRAC_BITS{1'b0}}};
        load_ok         = (frame_count != '0) && !(reverse_flag && once_flag)
                          && (total_reg < CNT_W'(TRACKS));
        load_entry.object_id  = object_id;
        load_entry.last_frame = load_last_frame;
        load_entry.reverse    = reverse_flag;
        load_entry.once       = once_flag;
        load_entry.finished   = 1'b0;
        if (reverse_flag || (CMP_W'(start_frame) > CMP_W'(load_last_pos)))
        begin
            load_entry.position = load_last_pos;
        end
        else
        begin
            load_entry.position = POS_W'(start_frame);
        end
    end

    // Hold parks the track at zero, finished; fire sets the direction and may
    // jump straight to its end.
    always_comb
    begin
        found_entry = mem_rd_data;
        found_entry.once = 1'b1;
        if (find_fire_reg)
        begin
            found_entry.reverse  = !open_reg;
            found_entry.finished = at_once_reg;
            if (at_once_reg)
            begin
                found_entry.position = open_reg
                    ? {mem_rd_data.last_frame, {FRAC_BITS{1'b0}}} : '0;
            end
        end
        else
        begin
            found_entry.position = '0;
            found_entry.reverse  = 1'b1;
            found_entry.finished = 1'b1;
        end
    end

    // Memory access. A step reads entry i while it writes back entry i-1, and
    // every entry is visited once, so no read ever meets a pending write to
    // the same entry.
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = p1_idx_reg;
        mem_wr_data = stepped;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_wr_en   = accept && (command == CMD_LOAD) && load_ok;
                mem_wr_addr = total_reg[IDX_W-1:0];
                mem_wr_data = load_entry;
            end
            ST_STEP:
            begin
                mem_rd_en = more_to_read && (!p1_valid_reg || step_consume);
                mem_wr_en = step_consume;
            end
            ST_FIND:
            begin
                mem_rd_en   = more_to_read && !find_end;
                mem_wr_en   = find_hit;
                mem_wr_data = found_entry;
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
        mem_rd_addr = rd_idx_reg[IDX_W-1:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        rd_idx_next = mem_rd_en ? rd_idx_reg + CNT_W'(1) : rd_idx_reg;
        p1_idx_next = mem_rd_en ? rd_idx_reg[IDX_W-1:0] : p1_idx_reg;
        p1_valid_next = mem_rd_en
            || (p1_valid_reg && !step_consume && (state_reg != ST_FIND));
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next   = '0;
                p1_valid_next = 1'b0;
                if (accept)
                begin
                    case (command) inside
                        CMD_CLEAR:
                        begin
                            total_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (load_ok)
                            begin
                                total_next = total_reg + CNT_W'(1);
                            end
                        end
                        CMD_STEP:
                        begin
                            if (total_reg != '0)
                            begin
                                state_next = ST_STEP;
                            end
                        end
                        CMD_HOLD, CMD_FIRE:
                        begin
                            if (total_reg != '0)
                            begin
                                state_next = ST_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                if (step_consume && p1_is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIND:
            begin
                if (find_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign product = PROD_W'(seconds) * PROD_W'(fps_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            rd_idx_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            fps_reg       <= FPS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            rd_idx_reg   <= rd_idx_next;
            p1_valid_reg <= p1_valid_next;
            if (cfg_wr_en)
            begin
                fps_reg <= cfg_wr_data;
            end
            if (step_consume)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= p1_idx_next;
        if (accept)
        begin
            adv_reg       <= ADV_W'(product >> SHIFT);
            find_id_reg   <= object_id;
            find_fire_reg <= (command == CMD_FIRE);
            open_reg      <= open_flag;
            at_once_reg   <= at_once_flag;
        end
        if (step_consume)
        begin
            track_object_reg <= mem_rd_data.object_id;
            frame_value_reg  <= FRAME_W'(mem_rd_data.position);
            is_last_reg      <= p1_is_last;
        end
    end

endmodule

`default_nettype wire

@@ design/ats_track_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Track table: one write port, one read port with registered read data.
// The read data holds while no read is issued.
module ats_track_mem
    import ats_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [TRACKS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/ats_track_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Advances one track entry by one time step.
module ats_track_update
    import ats_pkg::*;
(
    input  wire entry_t           cur,
    input  wire logic [ADV_W-1:0] adv,
    output entry_t                nxt
);

    logic [POS_W-1:0] adv_ext;
    logic [POS_W:0]   sum;
    logic [POS_W-1:0] sum_sat;
    logic [POS_W-1:0] last_pos;

    always_comb
    begin
        adv_ext  = POS_W'(adv);
        sum      = {1'b0, cur.position} + {1'b0, adv_ext};
        sum_sat  = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
        last_pos = {cur.last_frame, {FRAC_BITS{1'b0}}};
        nxt      = cur;
        if (!cur.finished)
        begin
            if (cur.reverse)
            begin
                if (cur.position <= adv_ext)
                begin
                    nxt.position = '0;
                    nxt.finished = 1'b1;
                end
                else
                begin
                    nxt.position = cur.position - adv_ext;
                end
            end
            else if (cur.once)
            begin
                if (sum_sat >= last_pos)
                begin
                    nxt.position = last_pos;
                    nxt.finished = 1'b1;
                end
                else
                begin
                    nxt.position = sum_sat;
                end
            end
            else
            begin
                // Looping tracks wrap once the integer part reaches the last frame.
                if (sum_sat[POS_W-1:FRAC_BITS] >= cur.last_frame)
                begin
                    nxt.position = '0;
                end
                else
                begin
                    nxt.position = sum_sat;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/ats_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the frame stepper.
module ats_checker
    import ats_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic [CMD_W-1:0]     command,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [ID_W-1:0]      track_object,
    input wire logic [FRAME_W-1:0]   frame_value,
    input wire logic                 is_last
);

    // A stalled result word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(track_object)
            && $stable(frame_value) && $stable(is_last))
        else $error("stalled result word changed");

    // Commands other than step never produce result words.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command != CMD_STEP) && !out_valid |=> !out_valid)
        else $error("result word after a non-step command");

    // While a step still has tracks to send, no new command is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> !in_ready)
        else $error("command accepted in the middle of a step");

    // Once a step's final word is taken by an idle block with no command
    // waiting, nothing follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_last && in_ready && !in_valid |=> !out_valid)
        else $error("result word after the final word of a step");

endmodule

bind animation_track_frame_stepper ats_checker u_ats_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .track_object (track_object),
    .frame_value  (frame_value),
    .is_last      (is_last)
);

`default_nettype wire

@@ bench/tb_animation_track_frame_stepper.sv @@
`timescale 1ns / 1ps

// Testbench for the animation track frame stepper.
//
// Every command word that the block accepts is also applied to a behavioral
// copy of the track table kept in this module. A step command yields one
// expected frame word per stored track, and those words are queued in table
// order. The output side pops the oldest expectation for every frame word
// that the block hands over and compares object id, frame position and the
// last-track mark.
//
// The run has a directed part and a random part. The directed part is a
// table of command words. A few of its rows carry the frame word typed in by
// hand, because the answer is obvious: an empty table, the largest frame
// count with the largest start position, and a one-frame reverse track. All
// other rows, and everything that follows, are checked against the
// behavioral table. The random part runs in phases. Each phase writes a new
// frame rate while the block is idle, clears the table, loads a batch of
// tracks, and then mixes steps, fires, holds, further loads, clears and
// unused command codes. Both channels idle at random, and some stretches
// run with no idling at all.
module tb_animation_track_frame_stepper;

    import ats_pkg::*;

    localparam int SUM_W           = POS_W + 1;
    localparam int DIRECTED_ROWS   = 25;
    localparam int PHASES          = 6;
    localparam int WORDS_PER_PHASE = 24;
    localparam int MAX_REPORTS     = 10;
    // Hold and fire search the table one entry per cycle, so the block can
    // still be busy after its last frame word.
    localparam int SETTLE_CYCLES   = TRACKS + 8;
    localparam int RUN_LIMIT_NS    = 10_000_000;

    // Command codes that the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    // One command word, as driven on the input channel.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ID_W-1:0]    id;
        logic [FC_W-1:0]    count;
        logic [FRAME_W-1:0] start;
        logic               rev;
        logic               once;
        logic               open;
        logic               at_once;
        logic [SECS_W-1:0]  secs;
    } cmd_word_t;

    // One frame word, as seen on the output channel.
    typedef struct packed {
        logic [ID_W-1:0]    obj;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } frame_rec_t;

    // How a directed row is checked: by the behavioral table, or against a
    // hand-written answer of no frame word or exactly one frame word.
    typedef enum logic [1:0] {
        BY_MODEL,
        TYPED_NONE,
        TYPED_ONE
    } row_check_t;

    typedef struct packed {
        cmd_word_t          word;
        row_check_t         check;
        logic [ID_W-1:0]    exp_obj;
        logic [FRAME_W-1:0] exp_frame;
    } directed_row_t;

    // The directed rows. Field order in each word: command, object id, frame
    // count, start frame, reverse, once, open, at once, seconds.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // A step on an empty table gives nothing.
        '{'{CMD_STEP, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF},
          TYPED_NONE, 8'h00, 20'h00000},
        // Loads that are skipped: zero frames, and reverse together with once.
        '{'{CMD_LOAD, 8'h00, 13'd0, 20'h00100, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_LOAD, 8'hAA, 13'd10, 20'h00200, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        // The frame count saturates to 4096 and the start clamps to frame 4095.
        '{'{CMD_LOAD, 8'hFF, 13'd8191, 20'hFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_STEP, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          TYPED_ONE, 8'hFF, 20'hFFF00},
        // Sitting on the last frame, the looping track wrapped to zero.
        '{'{CMD_STEP, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF},
          TYPED_ONE, 8'hFF, 20'h00000},
        '{'{CMD_CLEAR, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        // A one-frame reverse track starts and stays at zero.
        '{'{CMD_LOAD, 8'h01, 13'd1, 20'h12345, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_STEP, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF},
          TYPED_ONE, 8'h01, 20'h00000},
        '{'{CMD_CLEAR, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        // One track of each kind, and a second track with an id already used.
        '{'{CMD_LOAD, 8'h10, 13'd100, 20'h00000, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_LOAD, 8'h20, 13'd50, 20'h01080, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_LOAD, 8'h30, 13'd20, 20'h00000, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_LOAD, 8'h20, 13'd4096, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_STEP, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h8000},
          BY_MODEL, 8'h00, 20'h00000},
        // Hold with a match and with no match.
        '{'{CMD_HOLD, 8'h20, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_HOLD, 8'h77, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        // Fire forward, fire backward at once, fire forward at once, no match.
        '{'{CMD_FIRE, 8'h30, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_FIRE, 8'h10, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_FIRE, 8'h20, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_FIRE, 8'h99, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000},
          BY_MODEL, 8'h00, 20'h00000},
        // Unused command codes carrying busy fields must change nothing.
        '{'{CMD_SPARE_LO, 8'h10, 13'd7, 20'hABCDE, 1'b1, 1'b0, 1'b1, 1'b1, 16'hFFFF},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_SPARE_MID, 8'h20, 13'd9, 20'h54321, 1'b0, 1'b1, 1'b0, 1'b1, 16'h1234},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_SPARE_HI, 8'h30, 13'd4097, 20'hFFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF},
          BY_MODEL, 8'h00, 20'h00000},
        '{'{CMD_STEP, 8'h00, 13'd0, 20'h00000, 1'b0, 1'b0, 1'b0, 1'b0, 16'hFFFF},
          BY_MODEL, 8'h00, 20'h00000}
    };

    // Clock, reset and the block's inputs, all known from time zero.
    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [FPS_W-1:0]     cfg_wr_data  = '0;
    logic                 in_valid     = 1'b0;
    logic [CMD_W-1:0]     command      = CMD_CLEAR;
    logic [ID_W-1:0]      object_id    = '0;
    logic [FC_W-1:0]      frame_count  = '0;
    logic [FRAME_W-1:0]   start_frame  = '0;
    logic                 reverse_flag = 1'b0;
    logic                 once_flag    = 1'b0;
    logic                 open_flag    = 1'b0;
    logic                 at_once_flag = 1'b0;
    logic [SECS_W-1:0]    seconds      = '0;
    logic                 out_ready    = 1'b0;

    logic                 in_ready;
    logic                 out_valid;
    logic [ID_W-1:0]      track_object;
    logic [FRAME_W-1:0]   frame_value;
    logic                 is_last;

    // Behavioral copy of the frame rate and the track table.
    logic [FPS_W-1:0]     rate_q = FPS_RESET;
    int                   stored = 0;
    logic [ID_W-1:0]      trk_id    [TRACKS];
    logic [FC_W-1:0]      trk_count [TRACKS];
    logic [POS_W-1:0]     trk_pos   [TRACKS];
    logic                 trk_rev   [TRACKS];
    logic                 trk_once  [TRACKS];
    logic                 trk_done  [TRACKS];

    frame_rec_t           fresh_frames[$];    // frame words of the latest command
    frame_rec_t           pending_frames[$];  // frame words still owed by the block
    logic [ID_W-1:0]      recent_ids[$];      // ids loaded in this phase
    bit                   tx_calm = 1'b0;     // no input gaps while set
    int                   mismatch_count = 0;

    animation_track_frame_stepper u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .object_id    (object_id),
        .frame_count  (frame_count),
        .start_frame  (start_frame),
        .reverse_flag (reverse_flag),
        .once_flag    (once_flag),
        .open_flag    (open_flag),
        .at_once_flag (at_once_flag),
        .seconds      (seconds),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .track_object (track_object),
        .frame_value  (frame_value),
        .is_last      (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Position of the final frame of a track, in Q12.8.
    function automatic logic [POS_W-1:0] last_position(input logic [FC_W-1:0] count);
        return POS_W'(count - FC_W'(1)) << FRAC_BITS;
    endfunction

    // Slot of the first stored track with this object id, or -1.
    function automatic int find_track(input logic [ID_W-1:0] id);
        for (int i = 0; i < stored; i++)
        begin
            if (trk_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Applies one accepted command word to the behavioral table and leaves
    // the frame words it causes in fresh_frames.
    function automatic void apply_command(input cmd_word_t w);
        int                slot;
        logic [FC_W-1:0]   count;
        logic [POS_W-1:0]  tail;
        logic [PROD_W-1:0] prod;
        logic [POS_W-1:0]  adv;
        logic [SUM_W-1:0]  sum;
        frame_rec_t        rec;
        fresh_frames.delete();
        case (w.cmd)
            CMD_CLEAR:
                stored = 0;
            CMD_LOAD:
            begin
                if (w.count != '0 && !(w.rev && w.once) && stored < TRACKS)
                begin
                    count = (w.count > MAX_FRAMES) ? MAX_FRAMES : w.count;
                    tail  = last_position(count);
                    trk_id[stored]    = w.id;
                    trk_count[stored] = count;
                    trk_rev[stored]   = w.rev;
                    trk_once[stored]  = w.once;
                    trk_done[stored]  = 1'b0;
                    // Reverse tracks start at the end; others clamp the start.
                    if (w.rev || POS_W'(w.start) > tail)
                        trk_pos[stored] = tail;
                    else
                        trk_pos[stored] = POS_W'(w.start);
                    stored++;
                end
            end
            CMD_HOLD:
            begin
                slot = find_track(w.id);
                if (slot >= 0)
                begin
                    trk_pos[slot]  = '0;
                    trk_once[slot] = 1'b1;
                    trk_rev[slot]  = 1'b1;
                    trk_done[slot] = 1'b1;
                end
            end
            CMD_FIRE:
            begin
                slot = find_track(w.id);
                if (slot >= 0)
                begin
                    trk_once[slot] = 1'b1;
                    trk_rev[slot]  = !w.open;
                    trk_done[slot] = 1'b0;
                    if (w.at_once)
                    begin
                        trk_pos[slot]  = w.open ? last_position(trk_count[slot]) : '0;
                        trk_done[slot] = 1'b1;
                    end
                end
            end
            CMD_STEP:
            begin
                prod = PROD_W'(w.secs) * PROD_W'(rate_q);
                adv  = POS_W'(prod >> SHIFT);
                for (int i = 0; i < stored; i++)
                begin
                    // The frame word carries the position before the advance.
                    rec.obj   = trk_id[i];
                    rec.frame = FRAME_W'(trk_pos[i]);
                    rec.last  = (i == stored - 1);
                    fresh_frames.insert(fresh_frames.size(), rec);
                    tail = last_position(trk_count[i]);
                    if (trk_done[i])
                        continue;
                    if (trk_rev[i])
                    begin
                        if (trk_pos[i] <= adv)
                        begin
                            trk_pos[i]  = '0;
                            trk_done[i] = 1'b1;
                        end
                        else
                            trk_pos[i] = trk_pos[i] - adv;
                    end
                    else
                    begin
                        sum = SUM_W'(trk_pos[i]) + SUM_W'(adv);
                        if (sum > SUM_W'(POS_MAX))
                            sum = SUM_W'(POS_MAX);
                        if (trk_once[i])
                        begin
                            if (sum >= SUM_W'(tail))
                            begin
                                sum         = SUM_W'(tail);
                                trk_done[i] = 1'b1;
                            end
                        end
                        else if ((sum >> FRAC_BITS) >= SUM_W'(trk_count[i] - FC_W'(1)))
                            sum = '0;
                        trk_pos[i] = sum[POS_W-1:0];
                    end
                end
            end
            default:
                ;
        endcase
    endfunction

    // Builds a random command word of the given code. Every field starts
    // fully random so that unused fields toggle too; the fields that the
    // command reads are then shaped toward interesting values.
    function automatic cmd_word_t random_word(input logic [CMD_W-1:0] cmd);
        cmd_word_t w;
        int        r;
        w.cmd     = cmd;
        w.id      = ID_W'($urandom);
        w.count   = FC_W'($urandom);
        w.start   = FRAME_W'($urandom);
        w.rev     = 1'($urandom);
        w.once    = 1'($urandom);
        w.open    = 1'($urandom);
        w.at_once = 1'($urandom);
        w.secs    = SECS_W'($urandom);
        r = $urandom_range(0, 99);
        case (cmd) inside
            CMD_LOAD:
            begin
                // A small id pool makes duplicate ids common.
                if (r < 50)
                    w.id = ID_W'($urandom_range(0, 7));
                r = $urandom_range(0, 99);
                if (r < 5)
                    w.count = '0;
                else if (r < 55)
                    w.count = FC_W'($urandom_range(1, 24));
                else if (r < 75)
                    w.count = FC_W'($urandom_range(25, 600));
                else if (r < 85)
                    w.count = MAX_FRAMES;
                else if (r < 90)
                    w.count = FC_W'($urandom_range(4097, 8191));
                else
                    w.count = FC_W'($urandom_range(1, 4095));
                if ($urandom_range(0, 1) == 0)
                    w.start = FRAME_W'($urandom_range(0, 32'(w.count) * 256));
                // Reverse, once and looping tracks in about equal shares, a few with both flags set.
                r = $urandom_range(0, 99);
                w.rev  = (r < 30) || (r >= 92);
                w.once = (r >= 30 && r < 60) || (r >= 92);
                recent_ids.insert(recent_ids.size(), w.id);
            end
            CMD_HOLD, CMD_FIRE:
            begin
                if (r < 75 && recent_ids.size() != 0)
                    w.id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
            end
            CMD_STEP:
            begin
                if (r < 10)
                    w.secs = ($urandom_range(0, 1) == 1) ? {SECS_W{1'b1}} : '0;
                else if (r < 55)
                    w.secs = SECS_W'($urandom_range(0, 2048));
                else if (r < 80)
                    w.secs = SECS_W'($urandom_range(0, 16384));
            end
            default:
                ;
        endcase
        return w;
    endfunction

    // Offers one command word after a random gap and waits for the block to
    // take it. The word is then applied to the behavioral table, and when
    // use_model is set its frame words join the expected queue. Valid stays
    // high from one word to the next when there is no gap, so a single
    // assignment per edge drives it.
    task automatic send_word(input cmd_word_t w, input bit use_model);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= w.cmd;
        object_id    <= w.id;
        frame_count  <= w.count;
        start_frame  <= w.start;
        reverse_flag <= w.rev;
        once_flag    <= w.once;
        open_flag    <= w.open;
        at_once_flag <= w.at_once;
        seconds      <= w.secs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_command(w);
        if (use_model)
        begin
            foreach (fresh_frames[k])
                pending_frames.insert(pending_frames.size(), fresh_frames[k]);
        end
    endtask

    // Stimulus: reset, the directed rows, then the random phases.
    initial
    begin
        int               loads;
        int               r;
        logic [CMD_W-1:0] cmd;
        logic [FPS_W-1:0] rate;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows run at the reset frame rate of 30.
        foreach (directed_rows[n])
        begin
            send_word(directed_rows[n].word, directed_rows[n].check == BY_MODEL);
            if (directed_rows[n].check == TYPED_ONE)
                pending_frames.insert(pending_frames.size(),
                                      frame_rec_t'{directed_rows[n].exp_obj,
                                                   directed_rows[n].exp_frame, 1'b1});
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // The frame rate may change only while the block is idle: all
            // frame words are in, and a trailing hold or fire search has had
            // time to finish.
            in_valid <= 1'b0;
            while (pending_frames.size() != 0)
                @(posedge clk);
            repeat (TRACKS + 4) @(posedge clk);
            case (p)
                0: rate = '1;
                1: rate = FPS_W'(1);
                2: rate = '0;
                5: rate = FPS_RESET;
                default: rate = FPS_W'($urandom_range(2, 254));
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= rate;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            rate_q = rate;

            // Each phase starts from an empty table and loads a batch of
            // tracks; now and then more than the table holds.
            tx_calm = ($urandom_range(0, 3) == 0);
            recent_ids.delete();
            send_word(random_word(CMD_CLEAR), 1'b1);
            loads = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 19)
                                                : $urandom_range(1, 10);
            for (int k = 0; k < loads; k++)
                send_word(random_word(CMD_LOAD), 1'b1);

            for (int k = loads + 1; k < WORDS_PER_PHASE; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    cmd = CMD_STEP;
                else if (r < 65)
                    cmd = CMD_FIRE;
                else if (r < 75)
                    cmd = CMD_HOLD;
                else if (r < 88)
                    cmd = CMD_LOAD;
                else if (r < 92)
                    cmd = CMD_CLEAR;
                else
                    cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                send_word(random_word(cmd), 1'b1);
            end
        end

        // Drain, then give the block time to show any stray frame word.
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("animation_track_frame_stepper test passed");
        else
            $display("animation_track_frame_stepper test failed");
        $finish;
    end

    // Output side: checks every accepted frame word and drives out_ready.
    // Stalls are mostly short with an occasional long one, and the receiver
    // sometimes goes through stretches that take a word every cycle.
    initial
    begin
        frame_rec_t want;
        int         stall_left;
        int         rx_ticks;
        bit         rx_calm;
        stall_left = 0;
        rx_ticks   = 0;
        rx_calm    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected frame word: object %02h frame %05h last %0b",
                                 $time, track_object, frame_value, is_last);
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (track_object !== want.obj || frame_value !== want.frame ||
                        is_last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: frame word mismatch: expected object %02h ",
                                      "frame %05h last %0b, got object %02h frame %05h ",
                                      "last %0b"},
                                     $time, want.obj, want.frame, want.last,
                                     track_object, frame_value, is_last);
                    end
                end
            end

            rx_ticks++;
            if (rx_ticks % 300 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 99) < 20)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog for a block that hangs or drops frame words.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("animation_track_frame_stepper test failed");
        $finish;
    end

endmodule
